// ===== hdl/delta_varint_part_framer_assert.svh =====
// Assertion macros for the delta varint part framer.
// Used by the framer modules; expects clk and rst in scope.
`ifndef DELTA_VARINT_PART_FRAMER_ASSERT_SVH
`define DELTA_VARINT_PART_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define DVPF_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dvpf: same-cycle check failed");
`define DVPF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dvpf: next-cycle check failed");
`else
`define DVPF_ASSERT_IMPL(label, pre, post)
`define DVPF_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== hdl/dvpf_pkg.sv =====
// Shared types and constants for the delta varint part framer.
// No dependencies; used by the top level and dvpf_serial.
package dvpf_pkg;

  localparam int DefLengthBits  = 32;
  localparam int DefHeaderBytes = 5;

  localparam logic [7:0] TERM_BYTE = 8'h00;

  // Request codes carried on req_type
  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  // Load command from the input stage into the byte serializer
  typedef struct packed {
    logic valid;
    logic is_header;
    logic is_end;
  } load_t;

endpackage

// ===== hdl/delta_varint_part_framer.sv =====
// Path: a transaction is registered in the input stage, then loaded into the serializer's
// output register. Throughput: one data or finish item per cycle while out_ready stays high;
// a part start holds the output while its 1 to HEADER_BYTES header bytes are sent.
// Reset: synchronous, clears the stored previous length, the finished flag and
// both valid stages; no clearing pass.
// Top level; depends on dvpf_pkg, dvpf_encode, dvpf_serial and the assert header.
`include "delta_varint_part_framer_assert.svh"

module delta_varint_part_framer #(
  parameter int LENGTH_BITS  = dvpf_pkg::DefLengthBits,
  parameter int HEADER_BYTES = dvpf_pkg::DefHeaderBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] part_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        stream_end
);

  localparam int HDR_W = 7 * HEADER_BYTES;
  localparam int CNT_W = $clog2(HEADER_BYTES + 1);

  // Input stage
  logic                s1_valid;
  dvpf_pkg::req_t      s1_type;
  logic [31:0]         s1_len;
  logic [7:0]          s1_byte;

  // Framing state
  logic [LENGTH_BITS-1:0] previous_length;
  logic                   finished;

  logic                   s1_drop;
  logic                   s1_take;
  logic                   can_load;
  dvpf_pkg::load_t        ld;
  logic [7:0]             ld_byte;
  logic [LENGTH_BITS-1:0] len;
  logic [HDR_W-1:0]       hdr_val;
  logic [CNT_W-1:0]       hdr_bytes;

  assign in_ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
      s1_type  <= dvpf_pkg::req_t'(req_type);
      s1_len   <= part_length;
      s1_byte  <= data_byte;
    end
  end

  // Decode the held transaction
  always_comb begin
    ld.is_header = 1'b0;
    ld.is_end    = 1'b0;
    ld_byte      = s1_byte;
    s1_drop      = finished;
    case (s1_type)
      dvpf_pkg::REQ_START: begin
        ld.is_header = 1'b1;
      end
      dvpf_pkg::REQ_DATA: begin
        ld_byte = s1_byte;
      end
      dvpf_pkg::REQ_FINISH: begin
        ld.is_end = 1'b1;
        ld_byte   = dvpf_pkg::TERM_BYTE;
      end
      default: begin
        s1_drop = 1'b1;
      end
    endcase
    ld.valid = s1_valid && !s1_drop && can_load;
  end

  assign s1_take  = s1_valid && (s1_drop || can_load);

  dvpf_encode #(
    .LENGTH_BITS  (LENGTH_BITS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_encode (
    .prev_length (previous_length),
    .part_length (s1_len),
    .len         (len),
    .hdr_val     (hdr_val),
    .hdr_bytes   (hdr_bytes)
  );

  // Previous length and finished flag update as the header or terminator loads
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_length <= '0;
      finished        <= 1'b0;
    end else if (ld.valid) begin
      if (ld.is_header) begin
        previous_length <= len;
      end
      if (ld.is_end) begin
        finished <= 1'b1;
      end
    end
  end

  dvpf_serial #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_serial (
    .clk        (clk),
    .rst        (rst),
    .ld         (ld),
    .ld_byte    (ld_byte),
    .ld_val     (hdr_val),
    .ld_bytes   (hdr_bytes),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

  `DVPF_ASSERT_NEXT(a_finished_sticky, finished, finished)
  `DVPF_ASSERT_IMPL(a_no_load_after_finish, ld.valid, !finished)
  `DVPF_ASSERT_NEXT(a_stage_holds, s1_valid && !s1_take, s1_valid && $stable(s1_len))

endmodule

// ===== hdl/dvpf_encode.sv =====
// Header value encoder: raw length or zigzag(delta)+1, plus varint byte count.
// Pure combinational; depends on dvpf_pkg only through the top's parameters.
module dvpf_encode #(
  parameter int LENGTH_BITS  = 32,
  parameter int HEADER_BYTES = 5
) (
  input  logic [LENGTH_BITS-1:0]                  prev_length,
  input  logic [31:0]                             part_length,
  output logic [LENGTH_BITS-1:0]                  len,
  output logic [7*HEADER_BYTES-1:0]               hdr_val,
  output logic [$clog2(HEADER_BYTES+1)-1:0]       hdr_bytes
);

  localparam int VAL_W = LENGTH_BITS + 1;
  localparam int HDR_W = 7 * HEADER_BYTES;
  localparam int CNT_W = $clog2(HEADER_BYTES + 1);

  logic [LENGTH_BITS:0]   up_diff;
  logic [LENGTH_BITS-1:0] down_diff;
  logic [VAL_W-1:0]       val;
  logic [HEADER_BYTES-1:0] nz;

  assign len = LENGTH_BITS'(part_length);

  // Both differences in parallel; the borrow of up_diff gives the sign
  assign up_diff   = {1'b0, len} - {1'b0, prev_length};
  assign down_diff = prev_length - len;

  // zigzag(d)+1 is 2d+1 for d >= 0 and 2|d| for d < 0
  always_comb begin
    if (prev_length == '0) begin
      val = {1'b0, len};
    end else if (up_diff[LENGTH_BITS]) begin
      val = {down_diff, 1'b0};
    end else begin
      val = {up_diff[LENGTH_BITS-1:0], 1'b1};
    end
  end

  // One flag per byte: the first is always set, each other when bits remain above the group below it
  always_comb begin
    nz[0] = 1'b1;
    for (int k = 1; k < HEADER_BYTES; k++) begin
      nz[k] = ((val >> (7 * k)) != '0);
    end
  end

  assign hdr_bytes = CNT_W'($countones(nz));
  assign hdr_val   = HDR_W'(val);

endmodule

// ===== hdl/dvpf_serial.sv =====
// Output result register and varint byte serializer.
// Depends on dvpf_pkg and delta_varint_part_framer_assert.svh.
`include "delta_varint_part_framer_assert.svh"

module dvpf_serial #(
  parameter int HEADER_BYTES = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dvpf_pkg::load_t                     ld,
  input  logic [7:0]                          ld_byte,
  input  logic [7*HEADER_BYTES-1:0]           ld_val,
  input  logic [$clog2(HEADER_BYTES+1)-1:0]   ld_bytes,
  output logic                                can_load,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic                                run_last,
  output logic                                stream_end
);

  localparam int HDR_W  = 7 * HEADER_BYTES;
  localparam int REST_W = HDR_W - 7;
  localparam int CNT_W  = $clog2(HEADER_BYTES + 1);

  logic [REST_W-1:0] rest;
  logic [CNT_W-1:0]  remain;

  // Free when no byte is held, or in the cycle the last byte of the current transaction is taken
  assign can_load = !out_valid || (out_ready && remain == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld.valid) begin
      out_valid  <= 1'b1;
      stream_end <= ld.is_end;
      rest       <= ld_val[HDR_W-1:7];
      if (ld.is_header) begin
        out_byte <= {ld_bytes != CNT_W'(1), ld_val[6:0]};
        run_last <= (ld_bytes == CNT_W'(1));
        remain   <= ld_bytes - CNT_W'(1);
      end else begin
        out_byte <= ld_byte;
        run_last <= 1'b1;
        remain   <= '0;
      end
    end else if (out_valid && out_ready) begin
      if (remain != '0) begin
        // Next header group; continuation bit clear on the final one
        out_byte   <= {remain != CNT_W'(1), rest[6:0]};
        run_last   <= (remain == CNT_W'(1));
        stream_end <= 1'b0;
        rest       <= rest >> 7;
        remain     <= remain - CNT_W'(1);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  `DVPF_ASSERT_IMPL(a_load_when_free, ld.valid, can_load)
  `DVPF_ASSERT_IMPL(a_last_matches_count, out_valid, run_last == (remain == '0))
  `DVPF_ASSERT_IMPL(a_cont_bit, out_valid && !run_last, out_byte[7])
  `DVPF_ASSERT_IMPL(a_end_is_term, out_valid && stream_end, run_last && out_byte == dvpf_pkg::TERM_BYTE)

endmodule
